### design/integer_calculator_alu_macros.svh
// ----------------------------------------------------------------------------
// integer_calculator_alu_macros
// Assertion macros used by the port-level checker of the integer calculator.
// ----------------------------------------------------------------------------
`ifndef INTEGER_CALCULATOR_ALU_MACROS_SVH
`define INTEGER_CALCULATOR_ALU_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ICALC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ICALC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/icalc_pkg.sv
// ----------------------------------------------------------------------------
// icalc_pkg
// Types, codes and sizes shared by the integer calculator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package icalc_pkg;

   // operand and result width of the words
   localparam int DATA_WIDTH = 32;
   // internal width: holds any factorial up to 20! exactly
   localparam int WIDE_WIDTH = 64;
   // multiplier digit consumed per step
   localparam int DIGIT_WIDTH = 8;
   localparam int MUL_STEPS = (DATA_WIDTH + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
   localparam int DIV_STEPS = WIDE_WIDTH;
   localparam int SQRT_STEPS = WIDE_WIDTH / 2;
   localparam int CNT_WIDTH = $clog2(WIDE_WIDTH + 1);
   localparam int PC_WIDTH = 6;
   localparam int DEFAULT_MAX_FACT_N = 12;

   // operation codes
   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_MOD  = 3'd4;
   localparam logic [2:0] OP_SQRT = 3'd5;
   localparam logic [2:0] OP_NPR  = 3'd6;
   localparam logic [2:0] OP_NCR  = 3'd7;

   // status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_DIV0    = 2'd1;
   localparam status_type ST_INVALID = 2'd2;

   // datapath operations
   typedef logic [3:0] dp_op_type;
   localparam dp_op_type DP_NOP       = 4'd0;
   localparam dp_op_type DP_ADD       = 4'd1;
   localparam dp_op_type DP_SUB       = 4'd2;
   localparam dp_op_type DP_MUL_INIT  = 4'd3;
   localparam dp_op_type DP_MUL_STEP  = 4'd4;
   localparam dp_op_type DP_DIV_LOAD  = 4'd5;
   localparam dp_op_type DP_DIV_PREP  = 4'd6;
   localparam dp_op_type DP_DIV_STEP  = 4'd7;
   localparam dp_op_type DP_SQRT_INIT = 4'd8;
   localparam dp_op_type DP_SQRT_STEP = 4'd9;
   localparam dp_op_type DP_PERM_INIT = 4'd10;
   localparam dp_op_type DP_PERM_STEP = 4'd11;
   localparam dp_op_type DP_FACT_INIT = 4'd12;
   localparam dp_op_type DP_FACT_STEP = 4'd13;

   // next-address modes
   typedef logic [2:0] seq_type;
   localparam seq_type SEQ_NEXT     = 3'd0;
   localparam seq_type SEQ_WAIT     = 3'd1;
   localparam seq_type SEQ_DISPATCH = 3'd2;
   localparam seq_type SEQ_JUMP     = 3'd3;
   localparam seq_type SEQ_EMIT     = 3'd4;

   // jump conditions
   typedef logic [2:0] cond_type;
   localparam cond_type COND_ALWAYS    = 3'd0;
   localparam cond_type COND_MORE      = 3'd1;
   localparam cond_type COND_CNT_ZERO  = 3'd2;
   localparam cond_type COND_DIV_ZERO  = 3'd3;
   localparam cond_type COND_SQRT_BAD  = 3'd4;
   localparam cond_type COND_FACT_BAD  = 3'd5;

   // result sources
   typedef logic [1:0] osrc_type;
   localparam osrc_type OSRC_ZERO = 2'd0;
   localparam osrc_type OSRC_Y    = 2'd1;
   localparam osrc_type OSRC_QUOT = 2'd2;
   localparam osrc_type OSRC_REM  = 2'd3;

   typedef struct packed {
      logic [2:0]            operation;
      logic [DATA_WIDTH-1:0] operand_a;
      logic [DATA_WIDTH-1:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result_value;
      status_type            status;
   } rsp_type;

   // one control word of the microprogram
   typedef struct packed {
      dp_op_type             dp_op;
      seq_type               seq;
      cond_type              cond;
      logic [PC_WIDTH-1:0]   target;
      osrc_type              osrc;
      status_type            status;
   } ctrl_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic [2:0] operation;
      logic       cnt_one;
      logic       cnt_zero;
      logic       div_zero;
      logic       sqrt_bad;
      logic       fact_bad;
   } flags_type;

endpackage

`default_nettype wire

### design/integer_calculator_alu.sv
// One request at a time; req_ready rises together with rsp_valid, so a new word
// is accepted only once the last result has entered the result slot. The work
// runs in sequencer loops (one multiplier digit, quotient bit or root bit per
// step); a held result stalls the next one.
// Synchronous reset returns the sequencer to fetch and empties the result slot.
// ----------------------------------------------------------------------------
// integer_calculator_alu
// Microcoded integer calculator: add, sub, mul, div, mod, sqrt, nPr and nCr.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_calculator_alu #(
   parameter int MAX_FACT_N = icalc_pkg::DEFAULT_MAX_FACT_N
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire icalc_pkg::req_type req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output icalc_pkg::rsp_type      rsp_word
);

   icalc_pkg::ctrl_type  ctrl;
   icalc_pkg::flags_type flags;
   logic [icalc_pkg::DATA_WIDTH-1:0] dp_value;
   logic                 emit;
   logic                 out_busy;
   logic                 accept;

   logic                 rsp_valid_ff, rsp_valid_in;
   icalc_pkg::rsp_type   rsp_word_ff,  rsp_word_in;

   assign accept   = req_valid && req_ready;
   assign out_busy = rsp_valid_ff && !rsp_ready;

   icalc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_busy  (out_busy),
      .flags     (flags),
      .ctrl      (ctrl),
      .req_ready (req_ready),
      .emit      (emit)
   );

   icalc_datapath #(
      .MAX_FACT_N (MAX_FACT_N)
   ) u_datapath (
      .clock        (clock),
      .load         (accept),
      .req_word     (req_word),
      .ctrl         (ctrl),
      .flags        (flags),
      .result_value (dp_value)
   );

   // result slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit) begin
         rsp_valid_in             = 1'b1;
         rsp_word_in.result_value = dp_value;
         rsp_word_in.status       = ctrl.status;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

### design/icalc_useq.sv
// ----------------------------------------------------------------------------
// icalc_useq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module icalc_useq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 out_busy,
   input  wire icalc_pkg::flags_type flags,
   output icalc_pkg::ctrl_type       ctrl,
   output logic                      req_ready,
   output logic                      emit
);

   localparam int PW = icalc_pkg::PC_WIDTH;

   // control store addresses
   localparam logic [PW-1:0] A_FETCH     = 6'd0;
   localparam logic [PW-1:0] A_DISPATCH  = 6'd1;
   localparam logic [PW-1:0] A_ADD       = 6'd2;
   localparam logic [PW-1:0] A_ADD_OUT   = 6'd3;
   localparam logic [PW-1:0] A_SUB       = 6'd4;
   localparam logic [PW-1:0] A_SUB_OUT   = 6'd5;
   localparam logic [PW-1:0] A_MUL       = 6'd6;
   localparam logic [PW-1:0] A_MUL_LOOP  = 6'd7;
   localparam logic [PW-1:0] A_MUL_OUT   = 6'd8;
   localparam logic [PW-1:0] A_DIV       = 6'd9;
   localparam logic [PW-1:0] A_DIV_LOOP  = 6'd10;
   localparam logic [PW-1:0] A_DIV_OUT   = 6'd11;
   localparam logic [PW-1:0] A_MOD       = 6'd12;
   localparam logic [PW-1:0] A_MOD_LOOP  = 6'd13;
   localparam logic [PW-1:0] A_MOD_OUT   = 6'd14;
   localparam logic [PW-1:0] A_DIV0_OUT  = 6'd15;
   localparam logic [PW-1:0] A_SQRT      = 6'd16;
   localparam logic [PW-1:0] A_SQRT_LOOP = 6'd17;
   localparam logic [PW-1:0] A_SQRT_OUT  = 6'd18;
   localparam logic [PW-1:0] A_BAD_OUT   = 6'd19;
   localparam logic [PW-1:0] A_NPR       = 6'd20;
   localparam logic [PW-1:0] A_NPR_TEST  = 6'd21;
   localparam logic [PW-1:0] A_NPR_LOOP  = 6'd22;
   localparam logic [PW-1:0] A_NPR_OUT   = 6'd23;
   localparam logic [PW-1:0] A_NCR       = 6'd24;
   localparam logic [PW-1:0] A_NCR_TEST  = 6'd25;
   localparam logic [PW-1:0] A_NCR_LOOP  = 6'd26;
   localparam logic [PW-1:0] A_FACT      = 6'd27;
   localparam logic [PW-1:0] A_FACT_TEST = 6'd28;
   localparam logic [PW-1:0] A_FACT_LOOP = 6'd29;
   localparam logic [PW-1:0] A_QUOT      = 6'd30;
   localparam logic [PW-1:0] A_QUOT_LOOP = 6'd31;
   localparam logic [PW-1:0] A_NCR_OUT   = 6'd32;

   logic [PW-1:0] pc_ff;
   logic [PW-1:0] pc_in;
   logic [PW-1:0] pc_inc;
   logic          cond_true;

   // pack one control word
   function automatic icalc_pkg::ctrl_type uw(
      input icalc_pkg::dp_op_type  dp_op,
      input icalc_pkg::seq_type    seq,
      input icalc_pkg::cond_type   cond,
      input logic [PW-1:0]         target,
      input icalc_pkg::osrc_type   osrc,
      input icalc_pkg::status_type status
   );
      icalc_pkg::ctrl_type w;
      w.dp_op  = dp_op;
      w.seq    = seq;
      w.cond   = cond;
      w.target = target;
      w.osrc   = osrc;
      w.status = status;
      return w;
   endfunction

   // control store
   function automatic icalc_pkg::ctrl_type ucode(input logic [PW-1:0] addr);
      icalc_pkg::ctrl_type w;
      case (addr)
         A_FETCH:     w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_WAIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_DISPATCH:  w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_DISPATCH,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         // add, subtract
         A_ADD:       w = uw(icalc_pkg::DP_ADD, icalc_pkg::SEQ_NEXT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_ADD_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         A_SUB:       w = uw(icalc_pkg::DP_SUB, icalc_pkg::SEQ_NEXT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_SUB_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         // multiply, one digit per step
         A_MUL:       w = uw(icalc_pkg::DP_MUL_INIT, icalc_pkg::SEQ_NEXT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_MUL_LOOP:  w = uw(icalc_pkg::DP_MUL_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_MUL_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_MUL_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         // divide
         A_DIV:       w = uw(icalc_pkg::DP_DIV_LOAD, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_DIV_ZERO, A_DIV0_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_DIV_LOOP:  w = uw(icalc_pkg::DP_DIV_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_DIV_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_DIV_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_QUOT, icalc_pkg::ST_OK);
         // modulus
         A_MOD:       w = uw(icalc_pkg::DP_DIV_LOAD, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_DIV_ZERO, A_DIV0_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_MOD_LOOP:  w = uw(icalc_pkg::DP_DIV_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_MOD_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_MOD_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_REM, icalc_pkg::ST_OK);
         A_DIV0_OUT:  w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_DIV0);
         // square root, two radicand bits per step
         A_SQRT:      w = uw(icalc_pkg::DP_SQRT_INIT, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_SQRT_BAD, A_BAD_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_SQRT_LOOP: w = uw(icalc_pkg::DP_SQRT_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_SQRT_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_SQRT_OUT:  w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         A_BAD_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_INVALID);
         // nPr: product of n down to n-r+1
         A_NPR:       w = uw(icalc_pkg::DP_PERM_INIT, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_FACT_BAD, A_BAD_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NPR_TEST:  w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_CNT_ZERO, A_NPR_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NPR_LOOP:  w = uw(icalc_pkg::DP_PERM_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_NPR_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NPR_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         // nCr: nPr divided by r!
         A_NCR:       w = uw(icalc_pkg::DP_PERM_INIT, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_FACT_BAD, A_BAD_OUT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NCR_TEST:  w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_CNT_ZERO, A_FACT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NCR_LOOP:  w = uw(icalc_pkg::DP_PERM_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_NCR_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_FACT:      w = uw(icalc_pkg::DP_FACT_INIT, icalc_pkg::SEQ_NEXT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_FACT_TEST: w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_CNT_ZERO, A_QUOT,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_FACT_LOOP: w = uw(icalc_pkg::DP_FACT_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_FACT_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_QUOT:      w = uw(icalc_pkg::DP_DIV_PREP, icalc_pkg::SEQ_NEXT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_QUOT_LOOP: w = uw(icalc_pkg::DP_DIV_STEP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_MORE, A_QUOT_LOOP,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
         A_NCR_OUT:   w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_EMIT,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_Y, icalc_pkg::ST_OK);
         // unused addresses fall back to fetch
         default:     w = uw(icalc_pkg::DP_NOP, icalc_pkg::SEQ_JUMP,
                             icalc_pkg::COND_ALWAYS, A_FETCH,
                             icalc_pkg::OSRC_ZERO, icalc_pkg::ST_OK);
      endcase
      return w;
   endfunction

   // entry point of each operation
   function automatic logic [PW-1:0] dispatch(input logic [2:0] op);
      logic [PW-1:0] addr;
      case (op)
         icalc_pkg::OP_ADD:  addr = A_ADD;
         icalc_pkg::OP_SUB:  addr = A_SUB;
         icalc_pkg::OP_MUL:  addr = A_MUL;
         icalc_pkg::OP_DIV:  addr = A_DIV;
         icalc_pkg::OP_MOD:  addr = A_MOD;
         icalc_pkg::OP_SQRT: addr = A_SQRT;
         icalc_pkg::OP_NPR:  addr = A_NPR;
         icalc_pkg::OP_NCR:  addr = A_NCR;
         default:            addr = A_FETCH;
      endcase
      return addr;
   endfunction

   assign ctrl      = ucode(pc_ff);
   assign pc_inc    = pc_ff + PW'(1);
   assign req_ready = (pc_ff == A_FETCH);
   assign emit      = (ctrl.seq == icalc_pkg::SEQ_EMIT) && !out_busy;

   // jump condition
   always_comb begin
      case (ctrl.cond)
         icalc_pkg::COND_ALWAYS:   cond_true = 1'b1;
         icalc_pkg::COND_MORE:     cond_true = !flags.cnt_one;
         icalc_pkg::COND_CNT_ZERO: cond_true = flags.cnt_zero;
         icalc_pkg::COND_DIV_ZERO: cond_true = flags.div_zero;
         icalc_pkg::COND_SQRT_BAD: cond_true = flags.sqrt_bad;
         icalc_pkg::COND_FACT_BAD: cond_true = flags.fact_bad;
         default:                  cond_true = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      case (ctrl.seq)
         icalc_pkg::SEQ_NEXT:     pc_in = pc_inc;
         icalc_pkg::SEQ_WAIT:     pc_in = req_valid ? pc_inc : pc_ff;
         icalc_pkg::SEQ_DISPATCH: pc_in = dispatch(flags.operation);
         icalc_pkg::SEQ_JUMP:     pc_in = cond_true ? ctrl.target : pc_inc;
         icalc_pkg::SEQ_EMIT:     pc_in = out_busy ? pc_ff : A_FETCH;
         default:                 pc_in = A_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= A_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

### design/icalc_datapath.sv
// ----------------------------------------------------------------------------
// icalc_datapath
// Operand registers, work registers and the shared multiply, divide and
// square-root step logic, driven one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module icalc_datapath #(
   parameter int MAX_FACT_N = icalc_pkg::DEFAULT_MAX_FACT_N
) (
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire icalc_pkg::req_type   req_word,
   input  wire icalc_pkg::ctrl_type  ctrl,
   output icalc_pkg::flags_type      flags,
   output logic [icalc_pkg::DATA_WIDTH-1:0] result_value
);

   localparam int DW = icalc_pkg::DATA_WIDTH;
   localparam int WW = icalc_pkg::WIDE_WIDTH;
   localparam int GW = icalc_pkg::DIGIT_WIDTH;
   localparam int CW = icalc_pkg::CNT_WIDTH;
   localparam int KW = (MAX_FACT_N < 2) ? 1 : $clog2(MAX_FACT_N + 1);

   logic [2:0]    op_ff,  op_in;
   logic [DW-1:0] a_ff,   a_in;
   logic [DW-1:0] b_ff,   b_in;
   logic [WW-1:0] x_ff,   x_in;
   logic [WW-1:0] y_ff,   y_in;
   logic [WW-1:0] z_ff,   z_in;
   logic [KW-1:0] k_ff,   k_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic          neg_a, neg_b;
   logic [DW-1:0] mag_a, mag_b;
   logic [DW-1:0] sum_ab, diff_ab;
   logic [WW-1:0] mul_src, mul_prod;
   logic [GW-1:0] mul_digit;
   logic [WW-1:0] rem_shift, rem_sub;
   logic          rem_ge;
   logic [WW-1:0] sq_trial;
   logic          sq_ge;
   logic [DW-1:0] quot_lo, rem_lo;

   // operand sign and magnitude
   assign neg_a   = a_ff[DW-1];
   assign neg_b   = b_ff[DW-1];
   assign mag_a   = neg_a ? -a_ff : a_ff;
   assign mag_b   = neg_b ? -b_ff : b_ff;
   assign sum_ab  = a_ff + b_ff;
   assign diff_ab = a_ff - b_ff;

   // shared multiplier: wide word by one digit
   always_comb begin
      case (ctrl.dp_op)
         icalc_pkg::DP_PERM_STEP: mul_src = y_ff;
         icalc_pkg::DP_FACT_STEP: mul_src = z_ff;
         default:                 mul_src = x_ff;
      endcase
      if (ctrl.dp_op == icalc_pkg::DP_MUL_STEP) begin
         mul_digit = z_ff[GW-1:0];
      end else begin
         mul_digit = GW'(k_ff);
      end
   end
   assign mul_prod = mul_src * WW'(mul_digit);

   // restoring divide step: x remainder, y dividend in / quotient out
   assign rem_shift = {x_ff[WW-2:0], y_ff[WW-1]};
   assign rem_ge    = (rem_shift >= z_ff);
   assign rem_sub   = rem_shift - z_ff;

   // square-root step: x remainder, y root, z current bit
   assign sq_trial = y_ff + z_ff;
   assign sq_ge    = (x_ff >= sq_trial);

   // status to the sequencer
   assign flags.operation = op_ff;
   assign flags.cnt_one   = (cnt_ff == CW'(1));
   assign flags.cnt_zero  = (cnt_ff == '0);
   assign flags.div_zero  = (b_ff == '0);
   assign flags.sqrt_bad  = neg_a || (a_ff == '0);
   assign flags.fact_bad  = neg_a || neg_b || (mag_b > mag_a) ||
                            (mag_a > DW'(MAX_FACT_N));

   // result selection with sign fix-up
   assign quot_lo = y_ff[DW-1:0];
   assign rem_lo  = x_ff[DW-1:0];
   always_comb begin
      case (ctrl.osrc)
         icalc_pkg::OSRC_Y:    result_value = quot_lo;
         icalc_pkg::OSRC_QUOT: result_value = (neg_a ^ neg_b) ? -quot_lo : quot_lo;
         icalc_pkg::OSRC_REM:  result_value = neg_a ? -rem_lo : rem_lo;
         default:              result_value = '0;
      endcase
   end

   // operand capture
   always_comb begin
      op_in = op_ff;
      a_in  = a_ff;
      b_in  = b_ff;
      if (load) begin
         op_in = req_word.operation;
         a_in  = req_word.operand_a;
         b_in  = req_word.operand_b;
      end
   end

   // work registers per control word
   always_comb begin
      x_in   = x_ff;
      y_in   = y_ff;
      z_in   = z_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      case (ctrl.dp_op)
         icalc_pkg::DP_ADD: begin
            y_in = WW'(sum_ab);
         end
         icalc_pkg::DP_SUB: begin
            y_in = WW'(diff_ab);
         end
         icalc_pkg::DP_MUL_INIT: begin
            x_in   = WW'(a_ff);
            y_in   = '0;
            z_in   = WW'(b_ff);
            cnt_in = CW'(icalc_pkg::MUL_STEPS);
         end
         icalc_pkg::DP_MUL_STEP: begin
            y_in   = y_ff + mul_prod;
            x_in   = x_ff << GW;
            z_in   = z_ff >> GW;
            cnt_in = cnt_ff - CW'(1);
         end
         icalc_pkg::DP_DIV_LOAD: begin
            x_in   = '0;
            y_in   = WW'(mag_a);
            z_in   = WW'(mag_b);
            cnt_in = CW'(icalc_pkg::DIV_STEPS);
         end
         icalc_pkg::DP_DIV_PREP: begin
            x_in   = '0;
            cnt_in = CW'(icalc_pkg::DIV_STEPS);
         end
         icalc_pkg::DP_DIV_STEP: begin
            x_in   = rem_ge ? rem_sub : rem_shift;
            y_in   = {y_ff[WW-2:0], rem_ge};
            cnt_in = cnt_ff - CW'(1);
         end
         icalc_pkg::DP_SQRT_INIT: begin
            x_in   = WW'(a_ff);
            y_in   = '0;
            z_in   = WW'(1) << (WW - 2);
            cnt_in = CW'(icalc_pkg::SQRT_STEPS);
         end
         icalc_pkg::DP_SQRT_STEP: begin
            if (sq_ge) begin
               x_in = x_ff - sq_trial;
               y_in = (y_ff >> 1) + z_ff;
            end else begin
               y_in = y_ff >> 1;
            end
            z_in   = z_ff >> 2;
            cnt_in = cnt_ff - CW'(1);
         end
         icalc_pkg::DP_PERM_INIT: begin
            y_in   = WW'(1);
            k_in   = KW'(mag_a);
            cnt_in = CW'(mag_b);
         end
         icalc_pkg::DP_PERM_STEP: begin
            y_in   = mul_prod;
            k_in   = k_ff - KW'(1);
            cnt_in = cnt_ff - CW'(1);
         end
         icalc_pkg::DP_FACT_INIT: begin
            z_in   = WW'(1);
            k_in   = KW'(mag_b);
            cnt_in = CW'(mag_b);
         end
         icalc_pkg::DP_FACT_STEP: begin
            z_in   = mul_prod;
            k_in   = k_ff - KW'(1);
            cnt_in = cnt_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
   end

endmodule

`default_nettype wire

### design/icalc_checker.sv
// ----------------------------------------------------------------------------
// icalc_checker
// Port-level checks of the integer calculator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_calculator_alu_macros.svh"

module icalc_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire icalc_pkg::rsp_type rsp_word
);

   // a stalled result word holds
   `ICALC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_word), "stalled result word changed")

   // any error status carries a zero value
   `ICALC_ASSERT_SAME(a_err_zero, clock, reset,
      rsp_valid && (rsp_word.status != icalc_pkg::ST_OK),
      rsp_word.result_value == '0, "error result with nonzero value")

   // one word in flight: ready drops after an accept
   `ICALC_ASSERT_NEXT(a_one_busy, clock, reset, req_valid && req_ready,
      !req_ready, "request accepted while another is in flight")

   // a new result ends the work, so the sequencer is back at fetch
   `ICALC_ASSERT_SAME(a_emit_fetch, clock, reset, $rose(rsp_valid),
      req_ready, "result delivered without returning to fetch")

endmodule

bind integer_calculator_alu icalc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

`default_nettype wire

### verif/integer_calculator_alu_checker.sv
// ----------------------------------------------------------------------------
// integer_calculator_alu_checker
// Watches both channels of the calculator. It computes the answer for every
// accepted request word, queues it, and compares each accepted response word
// field by field against the oldest queued answer.
// ----------------------------------------------------------------------------
module integer_calculator_alu_checker #(
   parameter int MAX_FACT_N = icalc_pkg::DEFAULT_MAX_FACT_N
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire icalc_pkg::req_type req_word,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire icalc_pkg::rsp_type rsp_word,
   output int                      error_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [icalc_pkg::DATA_WIDTH-1:0] data_type;

   icalc_pkg::rsp_type answer_q[$];
   icalc_pkg::rsp_type oldest_answer;
   int                 fault_tally = 0;

   function automatic data_type magnitude_of(data_type v);
      return v[icalc_pkg::DATA_WIDTH-1] ? -v : v;
   endfunction

   function automatic data_type signed_as(data_type mag, logic neg);
      return neg ? -mag : mag;
   endfunction

   // floor of the square root, one root bit per pass
   function automatic data_type floor_root(data_type x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int bit_pos = icalc_pkg::DATA_WIDTH / 2; bit_pos >= 0; bit_pos--) begin
         trial = root | (64'd1 << bit_pos);
         if (trial * trial <= {32'd0, x})
            root = trial;
      end
      return root[icalc_pkg::DATA_WIDTH-1:0];
   endfunction

   // exact factorial, capped where 64 bits run out
   function automatic logic [63:0] factorial(data_type n);
      logic [63:0] prod;
      prod = 64'd1;
      for (int i = 2; i <= 20 && i <= n; i++)
         prod = prod * i;
      return prod;
   endfunction

   // answer the calculator gives for one request word
   function automatic icalc_pkg::rsp_type calc_expected(icalc_pkg::req_type w);
      icalc_pkg::rsp_type ans;
      data_type    a;
      data_type    b;
      data_type    mag_a;
      data_type    mag_b;
      logic        neg_a;
      logic        neg_b;
      logic [63:0] fact_n;
      logic [63:0] fact_nr;
      logic [63:0] quot;
      a = w.operand_a;
      b = w.operand_b;
      neg_a = a[icalc_pkg::DATA_WIDTH-1];
      neg_b = b[icalc_pkg::DATA_WIDTH-1];
      mag_a = magnitude_of(a);
      mag_b = magnitude_of(b);
      ans.result_value = '0;
      ans.status = icalc_pkg::ST_OK;
      case (w.operation)
         icalc_pkg::OP_ADD: ans.result_value = a + b;
         icalc_pkg::OP_SUB: ans.result_value = a - b;
         icalc_pkg::OP_MUL: ans.result_value = a * b;
         icalc_pkg::OP_DIV: begin
            if (mag_b == '0)
               ans.status = icalc_pkg::ST_DIV0;
            else
               ans.result_value = signed_as(mag_a / mag_b, neg_a != neg_b);
         end
         icalc_pkg::OP_MOD: begin
            if (mag_b == '0)
               ans.status = icalc_pkg::ST_DIV0;
            else
               ans.result_value = signed_as(mag_a % mag_b, neg_a);
         end
         icalc_pkg::OP_SQRT: begin
            if (neg_a || a == '0)
               ans.status = icalc_pkg::ST_INVALID;
            else
               ans.result_value = floor_root(a);
         end
         default: begin
            // permutations and combinations share the range check
            if (neg_a || neg_b || mag_b > mag_a || mag_a > MAX_FACT_N) begin
               ans.status = icalc_pkg::ST_INVALID;
            end else begin
               fact_n = factorial(mag_a);
               fact_nr = factorial(mag_a - mag_b);
               if (w.operation == icalc_pkg::OP_NPR)
                  quot = fact_n / fact_nr;
               else
                  quot = fact_n / (fact_nr * factorial(mag_b));
               ans.result_value = quot[icalc_pkg::DATA_WIDTH-1:0];
            end
         end
      endcase
      if (ans.status != icalc_pkg::ST_OK)
         ans.result_value = '0;
      return ans;
   endfunction

   // retire responses before queuing the new request of the same edge
   always @(posedge clock) begin
      if (reset) begin
         answer_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               $error("unexpected response word: result_value %0d status %0d",
                      $signed(rsp_word.result_value), rsp_word.status);
               fault_tally++;
            end else begin
               oldest_answer = answer_q.pop_front();
               if (rsp_word.result_value !== oldest_answer.result_value) begin
                  $error("result_value: expected %0d, actual %0d",
                         $signed(oldest_answer.result_value),
                         $signed(rsp_word.result_value));
                  fault_tally++;
               end
               if (rsp_word.status !== oldest_answer.status) begin
                  $error("status: expected %0d, actual %0d",
                         oldest_answer.status, rsp_word.status);
                  fault_tally++;
               end
            end
         end
         if (req_valid && req_ready)
            answer_q.push_back(calc_expected(req_word));
      end
      error_count <= fault_tally;
      pending_count <= answer_q.size();
   end

endmodule

### verif/integer_calculator_alu_tb.sv
// ----------------------------------------------------------------------------
// integer_calculator_alu_tb
// Drives the calculator with directed corner words for every operation, then
// a long random run, with random idling on both channels, one quiet stretch
// and one long response hold-off. The checker does all comparison.
// ----------------------------------------------------------------------------
module integer_calculator_alu_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = icalc_pkg::DATA_WIDTH;
   localparam int RANDOM_WORDS = 400;
   localparam int FACT_LIMIT = icalc_pkg::DEFAULT_MAX_FACT_N;
   // watchdog limit covers the slowest word, the response hold-off and sender gaps
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int HOLD_OFF_AT = 40;
   localparam int CALM_FIRST = 200;
   localparam int CALM_LAST = 280;
   localparam int TAIL_CYCLES = 120;

   localparam logic [DW-1:0] MOST_NEG = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] MOST_POS = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] MINUS_ONE = '1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   icalc_pkg::req_type req_word = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   icalc_pkg::rsp_type rsp_word;
   int                 error_count;
   int                 pending_count;
   int                 words_sent = 0;
   int                 stall_count = 0;

   integer_calculator_alu dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   integer_calculator_alu_checker #(.MAX_FACT_N(FACT_LIMIT)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic calm_stretch();
      return words_sent >= CALM_FIRST && words_sent < CALM_LAST;
   endfunction

   // offer one word, called at a clock edge; returns at its accepting edge
   task automatic send_word(logic [2:0] op, logic [DW-1:0] a, logic [DW-1:0] b);
      if (!calm_stretch() && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word.operation <= op;
      req_word.operand_a <= a;
      req_word.operand_b <= b;
      do @(posedge clock); while (!req_ready);
      words_sent <= words_sent + 1;
   endtask

   // mix of full-width, small signed and extreme operands
   function automatic logic [DW-1:0] pick_operand();
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0, 1, 2, 3: return $urandom();
         4, 5, 6:    return $urandom_range(40) - 20;
         7: begin
            case ($urandom_range(4))
               0:       return MOST_NEG;
               1:       return MOST_POS;
               2:       return '0;
               3:       return MINUS_ONE;
               default: return 1;
            endcase
         end
         default:    return $urandom_range(1000);
      endcase
   endfunction

   // receiver: random ready, a quiet stretch, and one long hold-off
   initial begin
      logic held;
      int   hold_left;
      held = 1'b0;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held && words_sent >= HOLD_OFF_AT) begin
            held = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= calm_stretch() || $urandom_range(99) >= 8;
         end
         @(posedge clock);
      end
   end

   // watchdog on cycles with no handshake on either channel
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_count = 0;
         else
            stall_count++;
         if (stall_count >= WATCHDOG_LIMIT) begin
            $display("integer_calculator_alu_tb: done, errors");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [2:0]    op;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      int            n;
      int            r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corner words for every operation
      send_word(icalc_pkg::OP_ADD, MOST_POS, 1);
      send_word(icalc_pkg::OP_ADD, MOST_NEG, MINUS_ONE);
      send_word(icalc_pkg::OP_SUB, MOST_NEG, 1);
      send_word(icalc_pkg::OP_SUB, '0, MOST_NEG);
      send_word(icalc_pkg::OP_MUL, MOST_POS, MOST_POS);
      send_word(icalc_pkg::OP_MUL, -7, 6);
      send_word(icalc_pkg::OP_DIV, 7, '0);
      send_word(icalc_pkg::OP_DIV, MOST_NEG, MINUS_ONE);
      send_word(icalc_pkg::OP_DIV, -7, 2);
      send_word(icalc_pkg::OP_MOD, MOST_NEG, MINUS_ONE);
      send_word(icalc_pkg::OP_MOD, -7, 2);
      send_word(icalc_pkg::OP_MOD, 7, '0);
      send_word(icalc_pkg::OP_MOD, 7, -2);
      send_word(icalc_pkg::OP_SQRT, '0, MOST_POS);
      send_word(icalc_pkg::OP_SQRT, MINUS_ONE, '0);
      send_word(icalc_pkg::OP_SQRT, MOST_POS, MINUS_ONE);
      send_word(icalc_pkg::OP_SQRT, 1, MOST_NEG);
      send_word(icalc_pkg::OP_NPR, FACT_LIMIT, FACT_LIMIT);
      send_word(icalc_pkg::OP_NPR, FACT_LIMIT + 1, 1);
      send_word(icalc_pkg::OP_NPR, 5, MINUS_ONE);
      send_word(icalc_pkg::OP_NPR, 5, '0);
      send_word(icalc_pkg::OP_NCR, FACT_LIMIT, FACT_LIMIT / 2);
      send_word(icalc_pkg::OP_NCR, '0, '0);
      send_word(icalc_pkg::OP_NCR, 3, 4);
      send_word(icalc_pkg::OP_NCR, MINUS_ONE, '0);

      // random words; n and r mostly in range for the factorial operations
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         op = $urandom_range(7);
         a = pick_operand();
         b = pick_operand();
         if ((op == icalc_pkg::OP_DIV || op == icalc_pkg::OP_MOD) &&
             $urandom_range(9) == 0)
            b = '0;
         if (op == icalc_pkg::OP_NPR || op == icalc_pkg::OP_NCR) begin
            if ($urandom_range(99) < 85) begin
               n = $urandom_range(FACT_LIMIT);
               r = $urandom_range(n);
               a = n;
               b = r;
            end else if ($urandom_range(1) == 0) begin
               n = $urandom_range(FACT_LIMIT + 5) - 2;
               r = $urandom_range(FACT_LIMIT + 5) - 2;
               a = n;
               b = r;
            end
         end
         send_word(op, a, b);
      end
      req_valid <= 1'b0;

      // drain, then let the block settle
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("integer_calculator_alu_tb: done, clean");
      else
         $display("integer_calculator_alu_tb: done, errors");
      $finish;
   end

endmodule
